// ===== hdl/drs_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// drs_pkg: shared types and constants for the damped resonator
// widths of the coefficient, drive and state words, register indexes and the
// coefficient bundle handed from the register file to the datapath
// ============================================================================
package drs_pkg;

	localparam int STATE_W   = 32;
	localparam int COEF_W    = 22;
	localparam int DRIVE_W   = 18;
	localparam int CFG_IDX_W = 2;

	localparam int DEF_UPDATE_SHIFT = 4;
	localparam int DEF_STATE_SHIFT  = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DAMPING  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE    = 2'd2;

	typedef struct packed {
		logic signed [COEF_W-1:0] damp;
		logic signed [COEF_W-1:0] rot;
		logic signed [COEF_W-1:0] gain;
	} coef_t;

endpackage

// ===== hdl/drs_coef_regs.sv =====
`timescale 1ns / 1ps
// ============================================================================
// drs_coef_regs: coefficient register file
// three signed coefficient registers written over the config channel,
// writes to an unused index are dropped
// ============================================================================
module drs_coef_regs
	import drs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [COEF_W-1:0]    wr_data,
	output coef_t                coef
);

	coef_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_DAMPING:  coef_q.damp <= wr_data;
				CFG_ROTATION: coef_q.rot  <= wr_data;
				CFG_DRIVE:    coef_q.gain <= wr_data;
				default:      coef_q      <= coef_q;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

// ===== hdl/drs_datapath.sv =====
`timescale 1ns / 1ps
// ============================================================================
// drs_datapath: one resonator update
// five coefficient products on the upper state bits and the drive, two
// wrapping sums, arithmetic scaling and the add into each state
// ============================================================================
module drs_datapath
	import drs_pkg::*;
#(
	parameter int UPDATE_SHIFT = DEF_UPDATE_SHIFT,
	parameter int STATE_SHIFT  = DEF_STATE_SHIFT
) (
	input  coef_t                      coef,
	input  logic signed [DRIVE_W-1:0]  drive,
	input  logic signed [STATE_W-1:0]  state_a,
	input  logic signed [STATE_W-1:0]  state_b,
	output logic signed [STATE_W-1:0]  next_a,
	output logic signed [STATE_W-1:0]  next_b
);

	localparam int HI_W = STATE_W - STATE_SHIFT;

	logic signed [HI_W-1:0]    hi_a, hi_b;
	logic signed [STATE_W-1:0] ha_x, hb_x, d_x, w_x, f_x, drv_x;
	logic signed [STATE_W-1:0] p_da, p_wb, p_fd, p_wa, p_db;
	logic signed [STATE_W-1:0] sum_a, sum_b;

	// upper state bits, i.e. state >>> STATE_SHIFT
	assign hi_a = state_a[STATE_W-1:STATE_SHIFT];
	assign hi_b = state_b[STATE_W-1:STATE_SHIFT];

	assign ha_x  = {{STATE_SHIFT{hi_a[HI_W-1]}}, hi_a};
	assign hb_x  = {{STATE_SHIFT{hi_b[HI_W-1]}}, hi_b};
	assign d_x   = {{(STATE_W-COEF_W){coef.damp[COEF_W-1]}}, coef.damp};
	assign w_x   = {{(STATE_W-COEF_W){coef.rot[COEF_W-1]}}, coef.rot};
	assign f_x   = {{(STATE_W-COEF_W){coef.gain[COEF_W-1]}}, coef.gain};
	assign drv_x = {{(STATE_W-DRIVE_W){drive[DRIVE_W-1]}}, drive};

	// products keep the low word only, wrapping like 32-bit integers
	assign p_da = d_x * ha_x;
	assign p_wb = w_x * hb_x;
	assign p_fd = f_x * drv_x;
	assign p_wa = w_x * ha_x;
	assign p_db = d_x * hb_x;

	assign sum_a = p_wb + p_fd - p_da;
	assign sum_b = '0 - p_wa - p_db;

	assign next_a = state_a + (sum_a >>> UPDATE_SHIFT);
	assign next_b = state_b + (sum_b >>> UPDATE_SHIFT);

endmodule

// ===== hdl/damped_resonator_step.sv =====
`timescale 1ns / 1ps
// ============================================================================
// damped_resonator_step: fixed-point damped second-order resonator
// coupled state-space form: each drive beat advances states a and b and
// returns both updated states as one result beat
// ============================================================================
//
// channel  direction  handshake             payload
// -------  ---------  --------------------  ------------------------------
// in       sink       in_valid / in_ready   drive (18b signed)
// out      source     out_valid / out_ready out_a, out_b (32b signed)
// cfg      sink       cfg_valid / cfg_ready cfg_index (2b), cfg_data (22b)
//
// path: drive beat -> input register -> state, which is the result register
// throughput: one beat per cycle while results are taken, bounded by the
//   state feedback loop through the five multipliers in drs_datapath
// stalls: a held result stops the state, the input register then fills and
//   in_ready drops; nothing is lost or repeated
// reset: coefficients and both states clear to zero, no clearing pass
// cfg_ready is always high; the user must write coefficients only while idle,
// and the block itself does not enforce it
module damped_resonator_step
	import drs_pkg::*;
#(
	parameter int UPDATE_SHIFT = DEF_UPDATE_SHIFT,
	parameter int STATE_SHIFT  = DEF_STATE_SHIFT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// drive beats
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [DRIVE_W-1:0]   drive,
	// result beats
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [STATE_W-1:0]   out_a,
	output logic signed [STATE_W-1:0]   out_b,
	// coefficient writes
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [COEF_W-1:0]           cfg_data
);

	coef_t coef;

	// input register
	logic                       valid_s1;
	logic signed [DRIVE_W-1:0]  drive_s1;

	// resonator state doubles as the result register
	logic                       out_valid_q;
	logic signed [STATE_W-1:0]  state_a_q, state_b_q;
	logic signed [STATE_W-1:0]  next_a, next_b;

	logic out_free;
	logic advance;

	assign cfg_ready = 1'b1;

	drs_coef_regs u_coef_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.coef     (coef)
	);

	drs_datapath #(
		.UPDATE_SHIFT (UPDATE_SHIFT),
		.STATE_SHIFT  (STATE_SHIFT)
	) u_datapath (
		.coef    (coef),
		.drive   (drive_s1),
		.state_a (state_a_q),
		.state_b (state_b_q),
		.next_a  (next_a),
		.next_b  (next_b)
	);

	// result slot is free once the held beat is taken
	assign out_free = !out_valid_q || out_ready;
	// the buffered drive beat commits to the state
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			drive_s1 <= drive;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// state is reset control: its zero value is the starting point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_a_q <= '0;
			state_b_q <= '0;
		end else if (advance) begin
			state_a_q <= next_a;
			state_b_q <= next_b;
		end
	end

	assign out_valid = out_valid_q;
	assign out_a     = state_a_q;
	assign out_b     = state_b_q;

	// state moves only when a drive beat commits
	a_state_hold : assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_a_q) && $stable(state_b_q))
		else $error("resonator state changed without a committed beat");

	// a committed beat always shows up as a result
	a_commit_result : assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("committed beat produced no result");

	// an empty input register never blocks the input
	a_ready_empty : assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with empty input register");

	// an accepted drive beat lands in the input register
	a_accept_fill : assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted drive beat was dropped");

endmodule

// ===== dv/damped_resonator_step_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// damped_resonator_step_test: self-checking bench for the damped resonator
// drives sample beats and coefficient writes, predicts both wrapped states
// after every sample in an internal model, and compares every result beat
// ============================================================================
module damped_resonator_step_test;
	import drs_pkg::*;

	// bench settings
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 120;
	localparam int DRAIN_PAD   = 6;
	localparam int PHASE_BEATS = 240;
	localparam int NUM_PHASES  = 8;

	// the one index the register file leaves unmapped; writes there are dropped
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

	localparam logic [COEF_W-1:0]  COEF_MAX  = 22'h1FFFFF;
	localparam logic [COEF_W-1:0]  COEF_MIN  = 22'h200000;
	localparam logic [DRIVE_W-1:0] DRIVE_MAX = 18'h1FFFF;
	localparam logic [DRIVE_W-1:0] DRIVE_MIN = 18'h20000;

	typedef struct {
		logic signed [STATE_W-1:0] a;
		logic signed [STATE_W-1:0] b;
	} state_pair_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic signed [DRIVE_W-1:0] drive;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [STATE_W-1:0] out_a;
	logic signed [STATE_W-1:0] out_b;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [COEF_W-1:0]         cfg_data;

	// predicted states of the resonator and its coefficients, sign-extended
	logic signed [STATE_W-1:0] st_a = '0;
	logic signed [STATE_W-1:0] st_b = '0;
	logic signed [STATE_W-1:0] k_damp = '0;
	logic signed [STATE_W-1:0] k_rot = '0;
	logic signed [STATE_W-1:0] k_gain = '0;

	// states still owed by the block, oldest first
	state_pair_t pending_states[$];

	int  errors = 0;
	int  drive_beats = 0;
	int  state_beats = 0;
	int  coef_writes = 0;
	int  cycle_count = 0;
	bit  tx_steady = 0;
	bit  rx_steady = 0;
	bit  hold_armed = 0;

	damped_resonator_step dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.drive     (drive),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_a     (out_a),
		.out_b     (out_b),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// one sample step of the coupled-form resonator; every product, sum and
	// update wraps at 32 bits and every right shift is sign-filling
	function automatic state_pair_t step_resonator(input logic signed [DRIVE_W-1:0] drv);
		logic signed [STATE_W-1:0] top_a;
		logic signed [STATE_W-1:0] top_b;
		logic signed [STATE_W-1:0] drv_w;
		logic signed [STATE_W-1:0] delta_a;
		logic signed [STATE_W-1:0] delta_b;
		state_pair_t               nxt;
		top_a   = st_a >>> DEF_STATE_SHIFT;
		top_b   = st_b >>> DEF_STATE_SHIFT;
		drv_w   = STATE_W'(drv);
		delta_a = (-k_damp) * top_a + k_rot * top_b + k_gain * drv_w;
		delta_b = (-k_rot) * top_a + (-k_damp) * top_b;
		nxt.a   = st_a + (delta_a >>> DEF_UPDATE_SHIFT);
		nxt.b   = st_b + (delta_b >>> DEF_UPDATE_SHIFT);
		return nxt;
	endfunction

	// monitor: all three channels sampled at the edge, before the edge's updates
	always @(posedge clk) begin
		state_pair_t nxt;
		state_pair_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				coef_writes++;
				case (cfg_index)
					CFG_DAMPING:  k_damp = {{(STATE_W-COEF_W){cfg_data[COEF_W-1]}}, cfg_data};
					CFG_ROTATION: k_rot  = {{(STATE_W-COEF_W){cfg_data[COEF_W-1]}}, cfg_data};
					CFG_DRIVE:    k_gain = {{(STATE_W-COEF_W){cfg_data[COEF_W-1]}}, cfg_data};
					default: ; // unmapped index, nothing changes
				endcase
			end
			if (in_valid && in_ready) begin
				nxt  = step_resonator(drive);
				st_a = nxt.a;
				st_b = nxt.b;
				pending_states.push_back(nxt);
				drive_beats++;
			end
			if (out_valid && out_ready) begin
				state_beats++;
				if (pending_states.size() == 0) begin
					$error("result beat with no sample outstanding: out_a %0d out_b %0d",
						out_a, out_b);
					errors++;
				end else begin
					want = pending_states.pop_front();
					if (out_a !== want.a) begin
						$error("out_a mismatch: expected %0d, got %0d", want.a, out_a);
						errors++;
					end
					if (out_b !== want.b) begin
						$error("out_b mismatch: expected %0d, got %0d", want.b, out_b);
						errors++;
					end
				end
			end
		end
	end

	// result side: random stalls, a steady mode, and one long hold on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_armed) begin
				hold_armed = 0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= rx_steady || ($urandom_range(99) >= 17);
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("timeout after %0d cycles, %0d results outstanding",
			cycle_count, pending_states.size());
		$display("== FAIL ==");
		$finish;
	end

	// one sample beat; called on a clock edge, returns on the accepting edge
	task automatic send_drive(input logic [DRIVE_W-1:0] value);
		if (!tx_steady) begin
			while ($urandom_range(99) < 17) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		drive    <= value;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// stop sending and wait until every owed result beat has come back
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_states.size() != 0) @(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(input logic [COEF_W-1:0] d, input logic [COEF_W-1:0] w,
			input logic [COEF_W-1:0] f);
		write_coef(CFG_DAMPING, d);
		write_coef(CFG_ROTATION, w);
		write_coef(CFG_DRIVE, f);
	endtask

	// coefficient by style: light damping, moderate rotation, an end, or anything
	function automatic logic [COEF_W-1:0] pick_coef(input int style);
		logic [COEF_W-1:0] v;
		case (style)
			0:       v = COEF_W'($urandom_range(1024));
			1:       v = COEF_W'(int'($urandom_range(262144)) - 131072);
			2:       v = $urandom_range(1) ? COEF_MAX : COEF_MIN;
			default: v = COEF_W'($urandom());
		endcase
		return v;
	endfunction

	function automatic logic [DRIVE_W-1:0] pick_drive();
		int roll;
		logic [DRIVE_W-1:0] v;
		roll = $urandom_range(99);
		if (roll < 70)
			v = DRIVE_W'($urandom());
		else if (roll < 90)
			v = DRIVE_W'(int'($urandom_range(511)) - 256);
		else
			v = $urandom_range(1) ? DRIVE_MAX : DRIVE_MIN;
		return v;
	endfunction

	// zero coefficients after reset: the states must not move at all
	task automatic test_reset_coefs();
		send_drive(DRIVE_MAX);
		send_drive(DRIVE_MIN);
		send_drive('0);
		settle();
	endtask

	// writes to the unmapped index are dropped
	task automatic test_unmapped_index();
		write_coef(CFG_UNMAPPED, COEF_MAX);
		write_coef(CFG_UNMAPPED, COEF_MIN);
		send_drive(DRIVE_MAX);
		send_drive(18'h00001);
		settle();
	endtask

	// a lightly damped oscillator kicked once, then left to ring
	task automatic test_impulse_ring();
		write_all(22'd64, 22'd52429, 22'd1048576);
		send_drive(DRIVE_MAX);
		repeat (9) send_drive('0);
		settle();
	endtask

	// coefficients and drive at both ends: products and states wrap
	task automatic test_wraparound();
		write_all(COEF_MAX, COEF_MIN, COEF_MAX);
		send_drive(DRIVE_MAX);
		send_drive(DRIVE_MIN);
		send_drive({DRIVE_W{1'b1}});
		send_drive(DRIVE_MAX);
		settle();
		write_all(COEF_MIN, COEF_MAX, COEF_MIN);
		send_drive(DRIVE_MIN);
		send_drive(DRIVE_MAX);
		send_drive('0);
		send_drive(DRIVE_MIN);
		settle();
	endtask

	// result side held off long enough that the block backs up into its input
	task automatic test_output_hold();
		write_all(pick_coef(0), pick_coef(1), pick_coef(3));
		tx_steady  = 1;
		hold_armed = 1;
		repeat (30) send_drive(pick_drive());
		tx_steady = 0;
		settle();
	endtask

	// random settings, one phase each, with a steady stretch and a mid-phase drain
	task automatic test_random_phases();
		int ph;
		int n;
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			write_all(pick_coef(ph % 4), pick_coef((ph + 1) % 4), pick_coef(3));
			if (ph == 6)
				write_coef(CFG_UNMAPPED, pick_coef(3));
			tx_steady = (ph == 3);
			rx_steady = (ph == 3);
			for (n = 0; n < PHASE_BEATS; n++) begin
				send_drive(pick_drive());
				if (ph == 5 && n == PHASE_BEATS / 2)
					settle(); // sender pauses until the pipe is empty
			end
			tx_steady = 0;
			rx_steady = 0;
			settle();
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		drive     = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_coefs();
		test_unmapped_index();
		test_impulse_ring();
		test_wraparound();
		test_output_hold();
		test_random_phases();

		if (pending_states.size() != 0) begin
			$error("%0d result beats never arrived", pending_states.size());
			errors++;
		end
		$display("covered %0d sample beats and %0d result beats over %0d coefficient writes,",
			drive_beats, state_beats, coef_writes);
		$display("including wraparound extremes, a long output hold and random stalls");
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
